@@ sv/pmcs_pkg.sv @@
`timescale 1ns / 1ps

package pmcs_pkg;

	localparam int RATIO_W    = 24;
	localparam int DEPTH_W    = 16;
	localparam int CFG_DATA_W = 24;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_FREQ_RATIO = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH  = 1'd1;

	localparam logic [RATIO_W-1:0] FREQ_RATIO_RESET = 24'd1024;
	localparam logic [DEPTH_W-1:0] MOD_DEPTH_RESET  = 16'd0;

	localparam longint unsigned PI_Q30       = 64'd3373259426;
	localparam int              TAYLOR_TERMS = 10;

	// Restoring long division; it only runs while the table is built at elaboration.
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Entry k of the quarter-wave table: cos(pi*k / 2^(addr_bits+1)) scaled to
	// 2^(sample_bits-1), evaluated with an integer Taylor series in Q30.
	function automatic longint unsigned cos_rom_entry(input int unsigned k,
		input int unsigned addr_bits, input int unsigned sample_bits);
		longint unsigned theta;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned quarter;
		quarter = 64'd1 << addr_bits;
		theta = (PI_Q30 * longint'(k) + quarter) >> (addr_bits + 1);
		x2 = (theta * theta + (64'd1 << 29)) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = div_u64((term * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return ((longint'(sum) << (sample_bits - 1)) + (64'd1 << 29)) >> 30;
	endfunction

endpackage

@@ sv/phase_modulation_cosine_shaper.sv @@
`timescale 1ns / 1ps

// Phase-modulation cosine shaper.
// Each input word is a signed sawtooth sample in half-turns. The block returns
// cos(pi * (x + depth * cos(pi * ratio * x))) in the same signed format, with
// a result of +1.0 saturated to the largest positive code.
// A word is taken at a rising edge where start is high and busy is low. Busy
// stays low, so a new word can enter on every cycle and the rate is one word
// per clock cycle.
// Each result appears on out_sample with done high for exactly one cycle,
// after its word has passed through the registered stages s1 to s8. Results
// leave in input order.
// The receiver cannot stall the block and every result is taken as it appears.
// The pipeline has two multiply stages and two reads of a registered
// quarter-wave cosine table. The ratio and depth registers are written through
// wr_en, wr_index and wr_data, by the user only while no word is in flight; the
// block does not enforce this. Writes to an unknown index are ignored.
// Reset clears all valid bits and loads ratio 1.0 and depth 0.
module phase_modulation_cosine_shaper
	import pmcs_pkg::*;
#(
	parameter int SAMPLE_BITS         = 16,
	parameter int COS_TABLE_ADDR_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] saw_sample,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic                          wr_en,
	input  logic [REG_IDX_W-1:0]          wr_index,
	input  logic [CFG_DATA_W-1:0]         wr_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int AB     = COS_TABLE_ADDR_BITS;
	localparam int ROM_N  = (1 << AB) + 1;
	localparam int P1W    = SB + 10;
	localparam int P2W    = SB + 16;
	localparam int SH1    = P1W - (AB + 2);
	localparam int SH2    = P2W - (AB + 2);

	localparam logic [P1W-1:0] RND1    = {{(P1W-1){1'b0}}, 1'b1} << (SH1 - 1);
	localparam logic [P2W-1:0] RND2    = {{(P2W-1){1'b0}}, 1'b1} << (SH2 - 1);
	localparam logic [AB:0]    QUARTER = {1'b1, {AB{1'b0}}};
	localparam logic [SB-1:0]  FULL    = {1'b1, {(SB-1){1'b0}}};
	localparam logic [SB-1:0]  MAXV    = {1'b0, {(SB-1){1'b1}}};

	typedef logic [SB-1:0] rom_t [ROM_N];

	typedef struct packed {
		logic        neg;
		logic [AB:0] addr;
	} rom_req_t;

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < ROM_N; k++) begin
			r[k] = SB'(cos_rom_entry(k, AB, SB));
		end
		return r;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	// Quadrant folding: odd quadrants read the table mirrored, the middle two
	// quadrants negate the value.
	function automatic rom_req_t rom_request(input logic [AB+1:0] idx);
		rom_req_t    req;
		logic [AB:0] off;
		off = {1'b0, idx[AB-1:0]};
		req.neg = idx[AB+1] ^ idx[AB];
		req.addr = idx[AB] ? (QUARTER - off) : off;
		return req;
	endfunction

	logic [RATIO_W-1:0] freq_ratio_q;
	logic [DEPTH_W-1:0] mod_depth_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;

	logic signed [SB-1:0] x_s1, x_s2, x_s3, x_s4;
	logic [P1W-1:0]       prod1_s1;
	rom_req_t             req1_s2;
	logic [SB-1:0]        rom1_s3;
	logic                 neg1_s3;
	logic [P2W-1:0]       prod2_s4;
	logic [P2W-1:0]       carrier_s5;
	rom_req_t             req2_s6;
	logic [SB-1:0]        rom2_s7;
	logic                 neg2_s7;
	logic [SB-1:0]        out_s8;

	logic signed [SB+24:0] prod1_full;
	logic [P1W-1:0]        phase1_rnd;
	logic signed [SB:0]    m_val;
	logic signed [SB+17:0] prod2_full;
	logic [SB:0]           y_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_ratio_q <= FREQ_RATIO_RESET;
			mod_depth_q  <= MOD_DEPTH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FREQ_RATIO: freq_ratio_q <= wr_data[RATIO_W-1:0];
				REG_MOD_DEPTH:  mod_depth_q  <= wr_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	assign prod1_full = saw_sample * $signed({1'b0, freq_ratio_q});
	assign phase1_rnd = prod1_s1 + RND1;
	assign m_val      = neg1_s3 ? -$signed({1'b0, rom1_s3}) : $signed({1'b0, rom1_s3});
	assign prod2_full = $signed({1'b0, mod_depth_q}) * m_val;
	assign y_neg      = -{1'b0, rom2_s7};

	always_ff @(posedge clk) begin
		x_s1       <= saw_sample;
		prod1_s1   <= prod1_full[P1W-1:0];
		x_s2       <= x_s1;
		req1_s2    <= rom_request(phase1_rnd[P1W-1 -: AB+2]);
		x_s3       <= x_s2;
		rom1_s3    <= COS_ROM[req1_s2.addr];
		neg1_s3    <= req1_s2.neg;
		x_s4       <= x_s3;
		prod2_s4   <= prod2_full[P2W-1:0];
		carrier_s5 <= {x_s4, 16'b0} + prod2_s4 + RND2;
		req2_s6    <= rom_request(carrier_s5[P2W-1 -: AB+2]);
		rom2_s7    <= COS_ROM[req2_s6.addr];
		neg2_s7    <= req2_s6.neg;
		if (neg2_s7) begin
			out_s8 <= y_neg[SB-1:0];
		end else if (rom2_s7 == FULL) begin
			out_s8 <= MAXV;
		end else begin
			out_s8 <= rom2_s7;
		end
	end

	assign busy       = 1'b0;
	assign done       = valid_s8;
	assign out_sample = $signed(out_s8);

endmodule

@@ test/phase_modulation_cosine_shaper_tb.sv @@
`timescale 1ns / 1ps

module phase_modulation_cosine_shaper_tb;
	import pmcs_pkg::*;

	localparam int SAMPLE_W     = 16;
	localparam int ADDR_W       = 10;
	localparam int QUARTER      = 1 << ADDR_W;
	localparam int SETTLE_WAIT  = 12;
	localparam int RANDOM_WORDS = 60;
	localparam int N_CORNERS    = 12;

	typedef bit [63:0] word64_t;

	class cosine_scoreboard;
		int                          quarter_cos [0:QUARTER];
		logic [RATIO_W-1:0]          ratio;
		logic [DEPTH_W-1:0]          depth;
		logic signed [SAMPLE_W-1:0]  expected_cos [$];
		int                          errors;

		function new();
			ratio  = FREQ_RATIO_RESET;
			depth  = MOD_DEPTH_RESET;
			errors = 0;
			for (int k = 0; k <= QUARTER; k++) begin
				quarter_cos[k] = table_entry(k);
			end
		endfunction

		function int table_entry(input int k);
			word64_t ang;
			word64_t ang2;
			word64_t term;
			longint  acc;
			ang  = (PI_Q30 * word64_t'(k) + word64_t'(QUARTER)) >> (ADDR_W + 1);
			ang2 = (ang * ang + (word64_t'(1) << 29)) >> 30;
			term = word64_t'(1) << 30;
			acc  = longint'(term);
			for (int n = 1; n <= 10; n++) begin
				term = ((term * ang2) >> 30) / word64_t'((2 * n - 1) * (2 * n));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			return int'(((word64_t'(acc) << (SAMPLE_W - 1)) + (word64_t'(1) << 29)) >> 30);
		endfunction

		function int cos_at(input word64_t phase, input int frac_bits);
			int      sh;
			word64_t p;
			int      idx;
			int      quad;
			int      off;
			sh   = frac_bits + 1 - (ADDR_W + 2);
			p    = phase & ((word64_t'(1) << (frac_bits + 1)) - 1);
			idx  = int'(((p + (word64_t'(1) << (sh - 1))) >> sh) & word64_t'(4 * QUARTER - 1));
			quad = idx >> ADDR_W;
			off  = idx & (QUARTER - 1);
			case (quad)
				0: begin
					return quarter_cos[off];
				end
				1: begin
					return -quarter_cos[QUARTER - off];
				end
				2: begin
					return -quarter_cos[off];
				end
				default: begin
					return quarter_cos[QUARTER - off];
				end
			endcase
		endfunction

		function logic signed [SAMPLE_W-1:0] shaped_cosine(input logic signed [SAMPLE_W-1:0] s);
			word64_t x;
			word64_t mod_phase;
			word64_t car_phase;
			int      m;
			int      y;
			x         = word64_t'(longint'(s));
			mod_phase = x * word64_t'(ratio);
			m         = cos_at(mod_phase, SAMPLE_W - 1 + 10);
			car_phase = (x << 16) + word64_t'(depth) * word64_t'(longint'(m));
			y         = cos_at(car_phase, SAMPLE_W - 1 + 16);
			if (y > (1 << (SAMPLE_W - 1)) - 1) begin
				y = (1 << (SAMPLE_W - 1)) - 1;
			end
			return y[SAMPLE_W-1:0];
		endfunction

		function void set_regs(input logic [RATIO_W-1:0] r, input logic [DEPTH_W-1:0] d);
			ratio = r;
			depth = d;
		endfunction

		function void note_word(input logic signed [SAMPLE_W-1:0] s);
			expected_cos.push_back(shaped_cosine(s));
		endfunction

		function void check_word(input logic signed [SAMPLE_W-1:0] y);
			logic signed [SAMPLE_W-1:0] want;
			if (expected_cos.size() == 0) begin
				$error("out_sample: expected no word, got %0d", y);
				errors++;
			end else begin
				want = expected_cos.pop_front();
				if (y !== want) begin
					$error("out_sample: expected %0d, got %0d", want, y);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_cos.size();
		endfunction
	endclass

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         start      = 1'b0;
	logic                         busy;
	logic signed [SAMPLE_W-1:0]   saw_sample = '0;
	logic                         done;
	logic signed [SAMPLE_W-1:0]   out_sample;
	logic                         wr_en      = 1'b0;
	logic [REG_IDX_W-1:0]         wr_index   = REG_FREQ_RATIO;
	logic [CFG_DATA_W-1:0]        wr_data    = '0;

	logic                         gaps_on    = 1'b1;
	logic [SAMPLE_W-1:0]          corner_words [N_CORNERS];
	cosine_scoreboard             board      = new();

	phase_modulation_cosine_shaper #(
		.SAMPLE_BITS(SAMPLE_W),
		.COS_TABLE_ADDR_BITS(ADDR_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.saw_sample(saw_sample),
		.done(done),
		.out_sample(out_sample),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			board.note_word(saw_sample);
		end
		if (arst_n && done) begin
			board.check_word(out_sample);
		end
	end

	task automatic send_word(input logic [SAMPLE_W-1:0] s);
		while (gaps_on && $urandom_range(99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		saw_sample <= s;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_regs(input logic [RATIO_W-1:0] r, input logic [DEPTH_W-1:0] d);
		wr_en    <= 1'b1;
		wr_index <= REG_FREQ_RATIO;
		wr_data  <= r;
		@(posedge clk);
		wr_index <= REG_MOD_DEPTH;
		wr_data  <= {8'($urandom_range(255)), d};
		@(posedge clk);
		wr_en <= 1'b0;
		board.set_regs(r, d);
	endtask

	initial begin
		logic [RATIO_W-1:0] r;
		logic [DEPTH_W-1:0] d;
		corner_words = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h4000,
			16'hC000, 16'h2000, 16'hE000, 16'h5555, 16'hAAAA, 16'h0100};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					r = FREQ_RATIO_RESET;
					d = MOD_DEPTH_RESET;
				end
				1: begin
					r = 24'd1;
					d = 16'hFFFF;
				end
				2: begin
					r = 24'd10240000;
					d = 16'hFFFF;
				end
				3: begin
					r = 24'd0;
					d = 16'h8000;
				end
				4: begin
					r = 24'hFFFFFF;
					d = 16'd1;
				end
				5: begin
					r = 24'd1024;
					d = 16'hFFFF;
				end
				6, 7: begin
					r = 24'($urandom_range(10240000, 1));
					d = 16'($urandom);
				end
				default: begin
					r = 24'($urandom);
					d = 16'($urandom);
				end
			endcase
			if (ph != 0) begin
				write_regs(r, d);
			end
			gaps_on = (ph != 3);
			if (ph == 0 || ph == 2) begin
				for (int i = 0; i < N_CORNERS; i++) begin
					send_word(corner_words[i]);
				end
			end
			for (int i = 0; i < RANDOM_WORDS; i++) begin
				if (ph == 1 && i == RANDOM_WORDS / 2) begin
					drain();
				end
				send_word(16'($urandom));
			end
			drain();
		end
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
